>>> hdl/tsr_pkg.sv
package tsr_pkg;

  localparam int IdW   = 16;
  localparam int CfgW  = 16;
  localparam int StW   = 2;
  localparam int IdxW  = 3;
  localparam int DivW  = CfgW + 1;
  localparam int ProdW = IdW + DivW;
  localparam int PosW  = ProdW + 1;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_CFG   = 2'd1;
  localparam logic [StW-1:0] ST_RANGE = 2'd2;

  localparam logic [IdxW-1:0] REG_PIC_WIDTH    = 3'd0;
  localparam logic [IdxW-1:0] REG_PIC_HEIGHT   = 3'd1;
  localparam logic [IdxW-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [IdxW-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [IdxW-1:0] REG_EDGE_MARGIN  = 3'd4;
  localparam logic [IdxW-1:0] REG_GAP_SPACING  = 3'd5;
  localparam logic [IdxW-1:0] REG_COLUMN_COUNT = 3'd6;
  localparam logic [IdxW-1:0] REG_TILE_LIMIT   = 3'd7;

  typedef struct packed {
    logic [CfgW-1:0] pic_width;
    logic [CfgW-1:0] pic_height;
    logic [CfgW-1:0] cell_width;
    logic [CfgW-1:0] cell_height;
    logic [CfgW-1:0] edge_margin;
    logic [CfgW-1:0] gap_spacing;
    logic [CfgW-1:0] column_count;
    logic [CfgW-1:0] tile_limit;
  } tsr_cfg_t;

  typedef struct packed {
    logic [DivW-1:0] rem;
    logic [DivW-1:0] quo;
    logic [DivW-1:0] den;
  } tsr_div_t;

  typedef struct packed {
    logic [IdW-1:0] tile_id;
    logic [StW-1:0] status;
    tsr_div_t       dv;
  } tsr_item_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [CfgW-1:0] src_x;
    logic [CfgW-1:0] src_y;
    logic [CfgW-1:0] src_w;
    logic [CfgW-1:0] src_h;
  } tsr_result_t;

endpackage

>>> hdl/tsr_channels.sv
interface tsr_req_if (
  input logic clk
);
  logic                     valid;
  logic                     ready;
  logic [tsr_pkg::IdW-1:0]  tile_id;

  modport source (output valid, output tile_id, input ready);
  modport sink (input valid, input tile_id, output ready);
endinterface

interface tsr_rsp_if (
  input logic clk
);
  logic                      valid;
  logic                      ready;
  logic [tsr_pkg::StW-1:0]   status;
  logic [tsr_pkg::CfgW-1:0]  src_x;
  logic [tsr_pkg::CfgW-1:0]  src_y;
  logic [tsr_pkg::CfgW-1:0]  src_w;
  logic [tsr_pkg::CfgW-1:0]  src_h;

  modport source (output valid, output status, output src_x, output src_y,
                  output src_w, output src_h, input ready);
  modport sink (input valid, input status, input src_x, input src_y,
                input src_w, input src_h, output ready);
endinterface

>>> hdl/tile_source_rect.sv
// Throughput: one request per cycle while the skid stage is empty.
// Two restoring dividers of 17 steps each (column count, then row and column)
// set the pipeline depth.
// A stalled result waits in an output register backed by one skid stage.
// Reset: synchronous rst clears all configuration registers to zero and
// empties the pipeline; no result is shown until a request has passed.
module tile_source_rect (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tsr_pkg::IdxW-1:0]  cfg_index,
  input  logic [tsr_pkg::CfgW-1:0]  cfg_data,
  tsr_req_if.sink                   req,
  tsr_rsp_if.source                 rsp
);

  tsr_pkg::tsr_cfg_t     cfg;
  logic                  adv;

  logic                  front_valid;
  tsr_pkg::tsr_item_t    front_item;
  tsr_pkg::tsr_item_t    front_next;
  logic [tsr_pkg::CfgW:0]   m2;
  logic [tsr_pkg::CfgW+1:0] need_w;
  logic [tsr_pkg::CfgW+1:0] need_h;
  logic [tsr_pkg::CfgW+1:0] num;

  logic [tsr_pkg::DivW:0] div1_valid;
  tsr_pkg::tsr_item_t     div1_item [tsr_pkg::DivW+1];
  logic [tsr_pkg::DivW:0] div2_valid;
  tsr_pkg::tsr_item_t     div2_item [tsr_pkg::DivW+1];

  logic                   mid_valid;
  tsr_pkg::tsr_item_t     mid_item;
  tsr_pkg::tsr_item_t     mid_next;
  logic [tsr_pkg::CfgW-1:0] cols;

  logic                   rect_valid;
  tsr_pkg::tsr_result_t   rect_res;
  tsr_pkg::tsr_result_t   out_res;

  tsr_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .we   (cfg_we),
    .idx  (cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  assign req.ready = adv;

  // config, tile-limit and image-size checks; column count dividend, divisor
  always_comb begin
    m2     = {cfg.edge_margin, 1'b0};
    need_w = {1'b0, m2} + {2'b0, cfg.cell_width};
    need_h = {1'b0, m2} + {2'b0, cfg.cell_height};
    num    = {2'b0, cfg.pic_width} - {1'b0, m2} + {2'b0, cfg.gap_spacing};
    front_next.tile_id = req.tile_id;
    priority if (cfg.pic_width == '0) begin
      front_next.status = tsr_pkg::ST_CFG;
    end else if (cfg.cell_width == '0 || cfg.cell_height == '0) begin
      front_next.status = tsr_pkg::ST_CFG;
    end else if (cfg.tile_limit != '0 && req.tile_id >= cfg.tile_limit) begin
      front_next.status = tsr_pkg::ST_RANGE;
    end else if ({2'b0, cfg.pic_width} < need_w
              || {2'b0, cfg.pic_height} < need_h) begin
      front_next.status = tsr_pkg::ST_CFG;
    end else begin
      front_next.status = tsr_pkg::ST_OK;
    end
    front_next.dv.rem = '0;
    front_next.dv.quo = num[tsr_pkg::DivW-1:0];
    front_next.dv.den = {1'b0, cfg.cell_width} + {1'b0, cfg.gap_spacing};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (adv) begin
      front_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_item <= front_next;
    end
  end

  assign div1_valid[0] = front_valid;
  assign div1_item[0]  = front_item;

  for (genvar k = 0; k < tsr_pkg::DivW; k++) begin : g_div1
    tsr_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (div1_valid[k]),
      .in_item   (div1_item[k]),
      .out_valid (div1_valid[k+1]),
      .out_item  (div1_item[k+1])
    );
  end

  // pick the column count in use and start the id division
  always_comb begin
    if (cfg.column_count != '0) begin
      cols = cfg.column_count;
    end else begin
      cols = div1_item[tsr_pkg::DivW].dv.quo[tsr_pkg::CfgW-1:0];
    end
    mid_next = div1_item[tsr_pkg::DivW];
    if (div1_item[tsr_pkg::DivW].status == tsr_pkg::ST_OK && cols == '0) begin
      mid_next.status = tsr_pkg::ST_CFG;
    end
    mid_next.dv.rem = '0;
    mid_next.dv.quo = {1'b0, div1_item[tsr_pkg::DivW].tile_id};
    mid_next.dv.den = {1'b0, cols};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (adv) begin
      mid_valid <= div1_valid[tsr_pkg::DivW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_item <= mid_next;
    end
  end

  assign div2_valid[0] = mid_valid;
  assign div2_item[0]  = mid_item;

  for (genvar k = 0; k < tsr_pkg::DivW; k++) begin : g_div2
    tsr_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (div2_valid[k]),
      .in_item   (div2_item[k]),
      .out_valid (div2_valid[k+1]),
      .out_item  (div2_item[k+1])
    );
  end

  tsr_rect u_rect (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (div2_valid[tsr_pkg::DivW]),
    .in_item   (div2_item[tsr_pkg::DivW]),
    .out_valid (rect_valid),
    .out_res   (rect_res)
  );

  tsr_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rect_valid),
    .in_res    (rect_res),
    .in_ready  (adv),
    .out_valid (rsp.valid),
    .out_res   (out_res),
    .out_ready (rsp.ready)
  );

  assign rsp.status = out_res.status;
  assign rsp.src_x  = out_res.src_x;
  assign rsp.src_y  = out_res.src_y;
  assign rsp.src_w  = out_res.src_w;
  assign rsp.src_h  = out_res.src_h;

endmodule

>>> hdl/tsr_cfg_regs.sv
module tsr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [tsr_pkg::IdxW-1:0]   idx,
  input  logic [tsr_pkg::CfgW-1:0]   data,
  output tsr_pkg::tsr_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (we) begin
      unique case (idx)
        tsr_pkg::REG_PIC_WIDTH:    cfg.pic_width    <= data;
        tsr_pkg::REG_PIC_HEIGHT:   cfg.pic_height   <= data;
        tsr_pkg::REG_CELL_WIDTH:   cfg.cell_width   <= data;
        tsr_pkg::REG_CELL_HEIGHT:  cfg.cell_height  <= data;
        tsr_pkg::REG_EDGE_MARGIN:  cfg.edge_margin  <= data;
        tsr_pkg::REG_GAP_SPACING:  cfg.gap_spacing  <= data;
        tsr_pkg::REG_COLUMN_COUNT: cfg.column_count <= data;
        tsr_pkg::REG_TILE_LIMIT:   cfg.tile_limit   <= data;
        default:                   cfg <= cfg;
      endcase
    end
  end

endmodule

>>> hdl/tsr_div_stage.sv
module tsr_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  tsr_pkg::tsr_item_t  in_item,
  output logic                out_valid,
  output tsr_pkg::tsr_item_t  out_item
);

  logic [tsr_pkg::DivW:0]   trial;
  logic [tsr_pkg::DivW:0]   diff;
  logic                     fits;
  tsr_pkg::tsr_item_t       step;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {in_item.dv.rem, in_item.dv.quo[tsr_pkg::DivW-1]};
    fits  = trial >= {1'b0, in_item.dv.den};
    diff  = trial - {1'b0, in_item.dv.den};
    step  = in_item;
    step.dv.rem = fits ? diff[tsr_pkg::DivW-1:0] : trial[tsr_pkg::DivW-1:0];
    step.dv.quo = {in_item.dv.quo[tsr_pkg::DivW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= step;
    end
  end

endmodule

>>> hdl/tsr_rect.sv
module tsr_rect (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  tsr_pkg::tsr_cfg_t    cfg,
  input  logic                 in_valid,
  input  tsr_pkg::tsr_item_t   in_item,
  output logic                 out_valid,
  output tsr_pkg::tsr_result_t out_res
);

  logic [tsr_pkg::DivW-1:0]  pitch_x;
  logic [tsr_pkg::DivW-1:0]  pitch_y;
  logic [tsr_pkg::ProdW-1:0] prod_x;
  logic [tsr_pkg::ProdW-1:0] prod_y;
  logic [tsr_pkg::PosW-1:0]  x_next;
  logic [tsr_pkg::PosW-1:0]  y_next;

  logic                      pos_valid;
  logic [tsr_pkg::StW-1:0]   pos_status;
  logic [tsr_pkg::PosW-1:0]  pos_x;
  logic [tsr_pkg::PosW-1:0]  pos_y;

  logic                      over;
  logic [tsr_pkg::StW-1:0]   st_final;
  tsr_pkg::tsr_result_t      res_next;

  // remainder is the column, quotient the row
  always_comb begin
    pitch_x  = {1'b0, cfg.cell_width} + {1'b0, cfg.gap_spacing};
    pitch_y  = {1'b0, cfg.cell_height} + {1'b0, cfg.gap_spacing};
    prod_x   = {{tsr_pkg::DivW{1'b0}}, in_item.dv.rem[tsr_pkg::IdW-1:0]}
             * {{tsr_pkg::IdW{1'b0}}, pitch_x};
    prod_y   = {{tsr_pkg::DivW{1'b0}}, in_item.dv.quo[tsr_pkg::IdW-1:0]}
             * {{tsr_pkg::IdW{1'b0}}, pitch_y};
    x_next   = {1'b0, prod_x} + tsr_pkg::PosW'(cfg.edge_margin);
    y_next   = {1'b0, prod_y} + tsr_pkg::PosW'(cfg.edge_margin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= 1'b0;
    end else if (adv) begin
      pos_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_status <= in_item.status;
      pos_x      <= x_next;
      pos_y      <= y_next;
    end
  end

  always_comb begin
    over = (pos_x + tsr_pkg::PosW'(cfg.cell_width)) > tsr_pkg::PosW'(cfg.pic_width)
        || (pos_y + tsr_pkg::PosW'(cfg.cell_height)) > tsr_pkg::PosW'(cfg.pic_height);
    if (pos_status == tsr_pkg::ST_OK && over) begin
      st_final = tsr_pkg::ST_RANGE;
    end else begin
      st_final = pos_status;
    end
    res_next.status = st_final;
    if (st_final == tsr_pkg::ST_OK) begin
      res_next.src_x = pos_x[tsr_pkg::CfgW-1:0];
      res_next.src_y = pos_y[tsr_pkg::CfgW-1:0];
      res_next.src_w = cfg.cell_width;
      res_next.src_h = cfg.cell_height;
    end else begin
      res_next.src_x = '0;
      res_next.src_y = '0;
      res_next.src_w = '0;
      res_next.src_h = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res_next;
    end
  end

endmodule

>>> hdl/tsr_out_buf.sv
module tsr_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tsr_pkg::tsr_result_t in_res,
  output logic                 in_ready,
  output logic                 out_valid,
  output tsr_pkg::tsr_result_t out_res,
  input  logic                 out_ready
);

  logic                 skid_valid;
  tsr_pkg::tsr_result_t skid_res;
  logic                 take;

  assign in_ready = !skid_valid;
  assign take     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // load out_res, or skid_res while output waits; take empties skid
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (in_valid) begin
      if (out_valid && !take) begin
        skid_res <= in_res;
      end else begin
        out_res <= in_res;
      end
    end
  end

endmodule

>>> hdl/tsr_checker.sv
module tsr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [tsr_pkg::StW-1:0]   rsp_status,
  input logic [tsr_pkg::CfgW-1:0]  src_x,
  input logic [tsr_pkg::CfgW-1:0]  src_y,
  input logic [tsr_pkg::CfgW-1:0]  src_w,
  input logic [tsr_pkg::CfgW-1:0]  src_h
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown straight after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == tsr_pkg::ST_OK || rsp_status == tsr_pkg::ST_CFG
                   || rsp_status == tsr_pkg::ST_RANGE))
    else $error("undefined status on result");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != tsr_pkg::ST_OK)
      |-> (src_x == '0 && src_y == '0 && src_w == '0 && src_h == '0))
    else $error("error result carries a rectangle");

  a_ok_size: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == tsr_pkg::ST_OK) |-> (src_w != '0 && src_h != '0))
    else $error("ok result with empty rectangle");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
      && $stable(src_x) && $stable(src_y) && $stable(src_w) && $stable(src_h)))
    else $error("stalled result changed");

endmodule

bind tile_source_rect tsr_checker u_tsr_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .src_x      (rsp.src_x),
  .src_y      (rsp.src_y),
  .src_w      (rsp.src_w),
  .src_h      (rsp.src_h)
);
